// ===== rtl/ugci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugci_pkg
// Shared types, widths and helpers of the uniform grid cell index block.
// ----------------------------------------------------------------------------
package ugci_pkg;

    localparam int AXES      = 3;
    localparam int MAX_AXES  = 3;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int INV_W     = 16;
    localparam int PROD_W    = COORD_W + INV_W;
    localparam int CELL_W    = PROD_W - 16;
    localparam int PARTS_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int PART_W    = 8;
    localparam int INDEX_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [PARTS_W-1:0] MAX_PARTS = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARTS   = 3'd0,
        REG_LOWER_0 = 3'd1,
        REG_LOWER_1 = 3'd2,
        REG_LOWER_2 = 3'd3,
        REG_INV_0   = 3'd4,
        REG_INV_1   = 3'd5,
        REG_INV_2   = 3'd6
    } cfg_reg_t;

    // stage advance strobes for the per-axis datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } axis_en_t;

    // zero means one cell, anything above sixteen means sixteen
    function automatic logic [PARTS_W-1:0] clamp_parts(input logic [PARTS_W-1:0] k);
        logic [PARTS_W-1:0] r;
        begin
            r = k;
            if (k == '0)
            begin
                r = 5'd1;
            end
            else if (k > MAX_PARTS)
            begin
                r = MAX_PARTS;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ugci_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugci_if
// Stream channels of the grid indexer: point words in, cell index words out.
// ----------------------------------------------------------------------------
interface ugci_coord_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ugci_pkg::COORD_W-1:0]    coord_0;
    logic signed [ugci_pkg::COORD_W-1:0]    coord_1;
    logic signed [ugci_pkg::COORD_W-1:0]    coord_2;

    modport source (output valid, coord_0, coord_1, coord_2, input ready);
    modport sink   (input valid, coord_0, coord_1, coord_2, output ready);
endinterface

interface ugci_index_if;
    logic                           valid;
    logic                           ready;
    logic [ugci_pkg::INDEX_W-1:0]   cell_index;

    modport source (output valid, cell_index, input ready);
    modport sink   (input valid, cell_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/ugci_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugci_axis
// One axis: subtract lower bound, scale by reciprocal width, floor and clamp.
// ----------------------------------------------------------------------------
module ugci_axis (
    input  wire logic                                   clk,
    input  wire ugci_pkg::axis_en_t                     en,
    input  wire logic signed [ugci_pkg::COORD_W-1:0]    coord,
    input  wire logic signed [ugci_pkg::COORD_W-1:0]    lower,
    input  wire logic [ugci_pkg::INV_W-1:0]             inv_width,
    input  wire logic [ugci_pkg::DIGIT_W-1:0]           last_cell,
    output logic [ugci_pkg::DIGIT_W-1:0]                digit
);

    logic signed [ugci_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic [ugci_pkg::CELL_W-1:0]        cell_reg, cell_next;
    logic [ugci_pkg::DIGIT_W-1:0]       digit_reg, digit_next;
    logic [ugci_pkg::PROD_W-1:0]        prod;

    // exact 17-bit difference
    assign diff_next = {coord[ugci_pkg::COORD_W-1], coord}
                     - {lower[ugci_pkg::COORD_W-1], lower};

    // a positive difference fits in 16 unsigned bits
    assign prod = diff_reg[ugci_pkg::COORD_W-1:0] * inv_width;

    always_comb
    begin
        if (diff_reg[ugci_pkg::DIFF_W-1] || diff_reg == '0)
        begin
            cell_next = '0;
        end
        else
        begin
            cell_next = prod[ugci_pkg::PROD_W-1:16];
        end
    end

    always_comb
    begin
        if (cell_reg > {{(ugci_pkg::CELL_W-ugci_pkg::DIGIT_W){1'b0}}, last_cell})
        begin
            digit_next = last_cell;
        end
        else
        begin
            digit_next = cell_reg[ugci_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            diff_reg <= diff_next;
        end
        if (en.s2)
        begin
            cell_reg <= cell_next;
        end
        if (en.s3)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule
`default_nettype wire

// ===== rtl/uniform_grid_cell_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_grid_cell_index
// Maps a 3-D Q8.8 point to its mixed-radix cell index in a uniform grid.
// ----------------------------------------------------------------------------
// pipeline: input word to output word through the subtract, multiply,
//   clamp, inner digit combine and outer digit combine registers
// throughput: one word per cycle unless the output stalls; each stage holds its word while stalled
// reset: pipeline valids cleared, K = 2, lower bounds 0, reciprocals 1.0
// ----------------------------------------------------------------------------
module uniform_grid_cell_index (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ugci_coord_if.sink                              in,
    ugci_index_if.source                            out,
    input  wire logic                               cfg_we,
    input  wire logic [ugci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ugci_pkg::CFG_DAT_W-1:0]     cfg_data
);

    logic [ugci_pkg::PARTS_W-1:0]       parts_reg;
    logic signed [ugci_pkg::COORD_W-1:0] lower_reg [ugci_pkg::MAX_AXES];
    logic [ugci_pkg::INV_W-1:0]         inv_reg [ugci_pkg::MAX_AXES];

    logic [ugci_pkg::PARTS_W-1:0]       k_eff;
    logic [ugci_pkg::DIGIT_W-1:0]       last_cell;

    logic [4:0]                         valid_reg;
    logic [4:0]                         en;
    ugci_pkg::axis_en_t                 axis_en;

    logic signed [ugci_pkg::COORD_W-1:0] coord [ugci_pkg::MAX_AXES];
    logic [ugci_pkg::DIGIT_W-1:0]       digit [ugci_pkg::MAX_AXES];

    logic [ugci_pkg::DIGIT_W-1:0]       low_reg;
    logic [ugci_pkg::PART_W-1:0]        part_reg, part_next;
    logic [ugci_pkg::INDEX_W-1:0]       index_reg, index_next;
    logic [ugci_pkg::PART_W+ugci_pkg::PARTS_W-1:0] outer_prod;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parts_reg <= 5'd2;
            for (int a = 0; a < ugci_pkg::MAX_AXES; a++)
            begin
                lower_reg[a] <= '0;
                inv_reg[a]   <= 16'd256;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ugci_pkg::REG_PARTS:   parts_reg    <= cfg_data[ugci_pkg::PARTS_W-1:0];
                ugci_pkg::REG_LOWER_0: lower_reg[0] <= cfg_data;
                ugci_pkg::REG_LOWER_1: lower_reg[1] <= cfg_data;
                ugci_pkg::REG_LOWER_2: lower_reg[2] <= cfg_data;
                ugci_pkg::REG_INV_0:   inv_reg[0]   <= cfg_data;
                ugci_pkg::REG_INV_1:   inv_reg[1]   <= cfg_data;
                ugci_pkg::REG_INV_2:   inv_reg[2]   <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign k_eff     = ugci_pkg::clamp_parts(parts_reg);
    assign last_cell = 4'(k_eff - 5'd1);

    // per-stage advance: a stage moves when empty or when its successor moves
    assign en[4] = !valid_reg[4] || out.ready;
    assign en[3] = !valid_reg[3] || en[4];
    assign en[2] = !valid_reg[2] || en[3];
    assign en[1] = !valid_reg[1] || en[2];
    assign en[0] = !valid_reg[0] || en[1];

    assign in.ready  = en[0];
    assign axis_en.s1 = en[0];
    assign axis_en.s2 = en[1];
    assign axis_en.s3 = en[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in.valid;
            end
            for (int s = 1; s < 5; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    assign coord[0] = in.coord_0;
    assign coord[1] = in.coord_1;
    assign coord[2] = in.coord_2;

    for (genvar a = 0; a < ugci_pkg::MAX_AXES; a++)
    begin : g_axis
        if (a < ugci_pkg::AXES)
        begin : g_used
            ugci_axis u_axis (
                .clk       (clk),
                .en        (axis_en),
                .coord     (coord[a]),
                .lower     (lower_reg[a]),
                .inv_width (inv_reg[a]),
                .last_cell (last_cell),
                .digit     (digit[a])
            );
        end
        else
        begin : g_unused
            assign digit[a] = '0;
        end
    end

    // horner form: index = d0 + K * (d1 + K * d2)
    assign part_next  = 8'(digit[1]) + 8'(k_eff) * 8'(digit[2]);
    assign outer_prod = k_eff * part_reg;
    assign index_next = ugci_pkg::INDEX_W'(outer_prod) + 12'(low_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            part_reg <= part_next;
            low_reg  <= digit[0];
        end
        if (en[4])
        begin
            index_reg <= index_next;
        end
    end

    assign out.valid      = valid_reg[4];
    assign out.cell_index = index_reg;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the uniform grid cell index block. A short table of
// points and register writes covers the corner cells, the clamps and the odd
// cell counts. Random grids with random points follow, with random stalls on
// both streams but in two quiet phases. Each word is checked against the table
// or an in-bench model of the per-axis floor, clamp and mixed-radix combine.
// ----------------------------------------------------------------------------
module testbench;
    import ugci_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t c2;
        coord_t c1;
        coord_t c0;
    } point_t;

    typedef struct {
        logic               is_cfg;
        cfg_reg_t           reg_sel;
        logic [15:0]        value;
        point_t             pt;
        logic               typed;
        logic [INDEX_W-1:0] want;
    } stim_row_t;

    localparam int RANDOM_PHASES   = 12;
    localparam int POINTS_PER_GRID = 112;
    localparam int IDLE_PCT        = 28;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 12;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    ugci_coord_if coord_ch ();
    ugci_index_if index_ch ();

    uniform_grid_cell_index dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (coord_ch),
        .out       (index_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the grid registers
    logic [PARTS_W-1:0] shadow_parts = 5'd2;
    coord_t             shadow_lower [3] = '{16'sd0, 16'sd0, 16'sd0};
    logic [INV_W-1:0]   shadow_inv [3]   = '{16'd256, 16'd256, 16'd256};

    logic [INDEX_W-1:0] pending_index [$];
    int                 mismatch_count = 0;
    logic               quiet = 1'b0;
    stim_row_t          directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [INDEX_W-1:0] grid_index(input point_t p);
        coord_t             axis_pt [3];
        logic signed [16:0] diff;
        logic [31:0]        prod;
        logic [15:0]        cell_num;
        int                 k;
        int                 weight;
        int                 sum;
        int                 a;
        axis_pt[0] = p.c0;
        axis_pt[1] = p.c1;
        axis_pt[2] = p.c2;
        k = int'(shadow_parts);
        if (k == 0)
        begin
            k = 1;
        end
        else if (k > 16)
        begin
            k = 16;
        end
        weight = 1;
        sum = 0;
        for (a = 0; a < AXES; a++)
        begin
            diff = {axis_pt[a][15], axis_pt[a]} - {shadow_lower[a][15], shadow_lower[a]};
            if (diff > 0)
            begin
                prod = {16'd0, diff[15:0]} * {16'd0, shadow_inv[a]};
                cell_num = prod[31:16];
                if (cell_num > k - 1)
                begin
                    cell_num = 16'(k - 1);
                end
                sum += weight * int'(cell_num);
            end
            weight *= k;
        end
        return 12'(sum);
    endfunction

    function automatic stim_row_t cfg_row(input cfg_reg_t r, input logic [15:0] v);
        return '{1'b1, r, v, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t pt_row(input coord_t c0, input coord_t c1, input coord_t c2,
                                         input logic typed, input logic [INDEX_W-1:0] want);
        point_t p;
        p.c0 = c0;
        p.c1 = c1;
        p.c2 = c2;
        return '{1'b0, REG_PARTS, 16'd0, p, typed, want};
    endfunction

    // half the time full range, often near the grid, sometimes right on an edge
    function automatic coord_t pick_coord(input int axis);
        int sel;
        int span;
        int v;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            return coord_t'($urandom);
        end
        if (sel < 85)
        begin
            span = (shadow_inv[axis] == 0) ? 65535 : 1048576 / int'(shadow_inv[axis]);
            if (span > 65535)
            begin
                span = 65535;
            end
            v = int'(shadow_lower[axis]) + int'($urandom_range(span)) - 16;
            if (v > 32767)
            begin
                v = 32767;
            end
            else if (v < -32768)
            begin
                v = -32768;
            end
            return coord_t'(v);
        end
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return shadow_lower[axis];
            default: return shadow_lower[axis] + 16'sd1;
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
        cfg_we = 1'b1;
        cfg_index = r;
        cfg_data = v;
        case (r)
            REG_PARTS:   shadow_parts = v[PARTS_W-1:0];
            REG_LOWER_0: shadow_lower[0] = v;
            REG_LOWER_1: shadow_lower[1] = v;
            REG_LOWER_2: shadow_lower[2] = v;
            REG_INV_0:   shadow_inv[0] = v;
            REG_INV_1:   shadow_inv[1] = v;
            REG_INV_2:   shadow_inv[2] = v;
            default:     ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        coord_ch.valid = 1'b0;
        while (pending_index.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_point(input point_t p, input logic typed,
                              input logic [INDEX_W-1:0] want);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            coord_ch.valid = 1'b0;
            @(negedge clk);
        end
        coord_ch.valid = 1'b1;
        coord_ch.coord_0 = p.c0;
        coord_ch.coord_1 = p.c1;
        coord_ch.coord_2 = p.c2;
        do
        begin
            @(posedge clk);
        end
        while (!coord_ch.ready);
        pending_index.push_back(typed ? want : grid_index(p));
        @(negedge clk);
    endtask

    // output side: random backpressure
    initial
    begin
        index_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            index_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // output side: compare each word with the oldest expected index
    initial
    begin
        logic [INDEX_W-1:0] exp_index;
        forever
        begin
            @(posedge clk);
            if (rst_n && index_ch.valid && index_ch.ready)
            begin
                if (pending_index.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("unexpected cell_index word %0d", index_ch.cell_index);
                    end
                end
                else
                begin
                    exp_index = pending_index.pop_front();
                    if (index_ch.cell_index !== exp_index)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("cell_index mismatch: expected %0d, got %0d",
                                     exp_index, index_ch.cell_index);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int          ph;
        int          n;
        int          r;
        logic [15:0] cfg_vals [7];
        point_t      p;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        coord_ch.valid = 1'b0;
        coord_ch.coord_0 = '0;
        coord_ch.coord_1 = '0;
        coord_ch.coord_2 = '0;

        // reset grid: two cells of width 1.0 per axis starting at 0
        directed_rows.push_back(pt_row(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 12'd0));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 12'd7));
        directed_rows.push_back(pt_row(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 12'd0));
        directed_rows.push_back(pt_row(16'sh0100, 16'sh0000, 16'sh0000, 1'b1, 12'd1));
        directed_rows.push_back(pt_row(16'sh0000, 16'sh0100, 16'sh0000, 1'b1, 12'd2));
        directed_rows.push_back(pt_row(16'sh0000, 16'sh0000, 16'sh0100, 1'b1, 12'd4));
        directed_rows.push_back(pt_row(16'sh00FF, 16'sh01FF, 16'shFFFF, 1'b1, 12'd2));
        directed_rows.push_back(pt_row(16'sh0001, 16'sh0001, 16'sh0001, 1'b1, 12'd0));
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd16));
        directed_rows.push_back(pt_row(16'sh1000, 16'sh0F00, 16'sh0A00, 1'b1, 12'd2815));
        directed_rows.push_back(cfg_row(REG_INV_0, 16'hFFFF));
        directed_rows.push_back(pt_row(16'sh0001, 16'sh0002, 16'sh0003, 1'b0, '0));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1, 12'd15));
        // zero reciprocal keeps the axis in cell 0
        directed_rows.push_back(cfg_row(REG_INV_2, 16'h0000));
        directed_rows.push_back(pt_row(16'sh0000, 16'sh0000, 16'sh7FFF, 1'b1, 12'd0));
        // points at and below the lower bounds
        directed_rows.push_back(cfg_row(REG_LOWER_0, 16'h7FFF));
        directed_rows.push_back(cfg_row(REG_LOWER_1, 16'h8000));
        directed_rows.push_back(cfg_row(REG_LOWER_2, 16'h0100));
        directed_rows.push_back(pt_row(16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 12'd240));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1, 12'd0));
        // zero cells acts as one, oversize counts saturate at sixteen
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd0));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 12'd0));
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd31));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 12'd240));
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd17));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 12'd240));
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd1));
        directed_rows.push_back(pt_row(16'sh04D2, 16'shFFFB, 16'sh7FFF, 1'b1, 12'd0));
        directed_rows.push_back(cfg_row(REG_PARTS, 16'd5));
        directed_rows.push_back(cfg_row(REG_INV_1, 16'h0155));
        directed_rows.push_back(cfg_row(REG_INV_2, 16'h0040));
        directed_rows.push_back(cfg_row(REG_LOWER_2, 16'hF800));
        directed_rows.push_back(pt_row(16'sh0123, 16'sh0456, 16'sh0000, 1'b0, '0));
        directed_rows.push_back(pt_row(16'shFFFE, 16'sh0300, 16'sh7000, 1'b0, '0));
        directed_rows.push_back(pt_row(16'sh7FFF, 16'sh0180, 16'sh0900, 1'b0, '0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
            begin
                send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            quiet = (ph == 3) || (ph == 4);
            case (ph)
                0:
                begin
                    cfg_vals = '{16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0};
                end
                1:
                begin
                    cfg_vals = '{16'd31, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF};
                end
                2:
                begin
                    // sixteen cells spread over the whole coordinate range
                    cfg_vals = '{16'd16, 16'h8000, 16'h8000, 16'h8000,
                                 16'h0010, 16'h0010, 16'h0010};
                end
                default:
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        case ($urandom_range(2))
                            0: cfg_vals[0] = 16'd0;
                            1: cfg_vals[0] = 16'd17;
                            default: cfg_vals[0] = 16'd31;
                        endcase
                    end
                    else
                    begin
                        cfg_vals[0] = 16'($urandom_range(1, 16));
                    end
                    for (r = 1; r <= 3; r++)
                    begin
                        cfg_vals[r] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(16384)) - 16'h2000;
                    end
                    for (r = 4; r <= 6; r++)
                    begin
                        cfg_vals[r] = ($urandom_range(7) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(16, 1024));
                    end
                end
            endcase
            for (r = 0; r < 7; r++)
            begin
                write_reg(cfg_reg_t'(r), cfg_vals[r]);
            end
            for (n = 0; n < POINTS_PER_GRID; n++)
            begin
                if (n == POINTS_PER_GRID / 2)
                begin
                    wait_idle();
                end
                p.c0 = pick_coord(0);
                p.c1 = pick_coord(1);
                p.c2 = pick_coord(2);
                send_point(p, 1'b0, '0);
            end
        end

        wait_idle();
        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_index.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
